>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define PTE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, off during reset.
`define PTE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/permt_pkg.sv
`timescale 1ns / 1ps
package permt_pkg;

  // Request field widths
  localparam int OP_W  = 3;
  localparam int NUM_W = 8;
  localparam int VAL_W = 7;
  localparam int RND_W = 31;
  localparam int CNT_W = $clog2(RND_W);

  typedef enum logic [OP_W-1:0] {
    OP_START   = 3'd0,
    OP_SHUFFLE = 3'd1,
    OP_APPEND  = 3'd2,
    OP_LOOKUP  = 3'd3,
    OP_SHORTEN = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_DIV,
    ST_RD_I,
    ST_RD_J,
    ST_WR_I,
    ST_WR_J,
    ST_LOOK,
    ST_SHORT,
    ST_DONE
  } state_t;

endpackage

>>> rtl/permutation_table_engine.sv
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// request   in_valid / in_stall  op, number, entry_value, random_word
// result    out_valid/ out_stall read_value, length, shuffle_done, error
//
// One request is worked at a time; the next is taken once the previous result
// sits in the output register, even while that result is still stalled.
// Start fills entry k with k; shuffle reduces random_word modulo the remaining length
// bit by bit, then swaps by reading i, reading j, writing i and writing j.
// Reset (rst, synchronous) empties the table and rewinds the shuffle position;
// table entries are not cleared. A stalled result blocks only the completion.
module permutation_table_engine #(
  parameter int MAX_ENTRIES = 128
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [permt_pkg::OP_W-1:0]  op,
  input  logic [permt_pkg::NUM_W-1:0] number,
  input  logic [permt_pkg::VAL_W-1:0] entry_value,
  input  logic [permt_pkg::RND_W-1:0] random_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  read_value,
  output logic [7:0]                  length,
  output logic                        shuffle_done,
  output logic                        error
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int LEN_W = $clog2(MAX_ENTRIES + 1);

  // Table storage: one write port, one registered read port
  logic [permt_pkg::VAL_W-1:0] entries [MAX_ENTRIES];
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_wa;
  logic [permt_pkg::VAL_W-1:0] mem_wd;
  logic [IDX_W-1:0]            mem_ra;
  logic [permt_pkg::VAL_W-1:0] rd_data;

  // Control state
  permt_pkg::state_t state, state_next;
  logic [LEN_W-1:0]  table_length, table_length_next;
  logic [LEN_W-1:0]  shuffle_position, shuffle_position_next;
  logic              out_valid_next;

  // Working registers of the current request
  logic [permt_pkg::NUM_W-1:0] num_reg;
  logic [permt_pkg::RND_W-1:0] rnd_reg;
  logic [LEN_W-1:0]            div_reg;
  logic [LEN_W-1:0]            rem;
  logic [permt_pkg::CNT_W-1:0] bit_cnt;
  logic [IDX_W-1:0]            swap_j;
  logic [permt_pkg::VAL_W-1:0] tmp;
  logic [LEN_W-1:0]            walk;
  logic [LEN_W-1:0]            wr_cnt;
  logic                        pend;
  logic [7:0]                  res_read;
  logic                        res_err;

  logic                        in_acc;
  logic                        slot_free;
  logic                        pos_at_end;
  logic                        tbl_full;
  logic [LEN_W-1:0]            start_len;
  logic [LEN_W:0]              div_shift;
  logic [LEN_W:0]              div_sub;
  logic                        div_ge;
  logic [LEN_W-1:0]            j_sum;
  logic                        walk_issue;
  logic                        keep_entry;

  assign in_acc     = in_valid && !in_stall;
  assign slot_free  = !out_valid || !out_stall;
  assign pos_at_end = shuffle_position >= table_length;
  assign tbl_full   = table_length >= LEN_W'(MAX_ENTRIES);
  assign start_len  = (number > 8'(MAX_ENTRIES)) ? LEN_W'(MAX_ENTRIES) : LEN_W'(number);

  // One restoring step of the modulo: shift in the next random bit, subtract
  assign div_shift  = {rem, rnd_reg[permt_pkg::RND_W-1]};
  assign div_sub    = div_shift - {1'b0, div_reg};
  assign div_ge     = div_shift >= {1'b0, div_reg};
  assign j_sum      = shuffle_position + rem;

  assign walk_issue = walk < table_length;
  assign keep_entry = 8'(rd_data) < num_reg;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entries[mem_wa] <= mem_wd;
    end
    rd_data <= entries[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= permt_pkg::ST_IDLE;
      table_length     <= '0;
      shuffle_position <= '0;
      out_valid        <= 1'b0;
    end else begin
      state            <= state_next;
      table_length     <= table_length_next;
      shuffle_position <= shuffle_position_next;
      out_valid        <= out_valid_next;
    end
  end

  always_comb begin
    state_next            = state;
    table_length_next     = table_length;
    shuffle_position_next = shuffle_position;
    mem_we                = 1'b0;
    mem_wa                = '0;
    mem_wd                = '0;
    mem_ra                = '0;
    in_stall              = (state != permt_pkg::ST_IDLE);
    out_valid_next        = out_valid && out_stall;

    unique case (state)
      permt_pkg::ST_IDLE: begin
        // Read speculatively for a lookup
        mem_ra = number[IDX_W-1:0];
        if (in_acc) begin
          state_next = permt_pkg::ST_DONE;
          unique case (op)
            permt_pkg::OP_START: begin
              table_length_next     = start_len;
              shuffle_position_next = '0;
              if (start_len != '0) begin
                state_next = permt_pkg::ST_FILL;
              end
            end
            permt_pkg::OP_SHUFFLE: begin
              if (!pos_at_end) begin
                state_next = permt_pkg::ST_DIV;
              end
            end
            permt_pkg::OP_APPEND: begin
              if (!tbl_full) begin
                mem_we            = 1'b1;
                mem_wa            = table_length[IDX_W-1:0];
                mem_wd            = entry_value;
                table_length_next = table_length + LEN_W'(1);
              end
            end
            permt_pkg::OP_LOOKUP: begin
              if (number < 8'(table_length)) begin
                state_next = permt_pkg::ST_LOOK;
              end
            end
            permt_pkg::OP_SHORTEN: begin
              if (8'(table_length) > number) begin
                state_next = permt_pkg::ST_SHORT;
              end
            end
            default: begin
              state_next = permt_pkg::ST_DONE;
            end
          endcase
        end
      end
      permt_pkg::ST_FILL: begin
        mem_we = 1'b1;
        mem_wa = walk[IDX_W-1:0];
        mem_wd = permt_pkg::VAL_W'(walk);
        if ((walk + LEN_W'(1)) == table_length) begin
          state_next = permt_pkg::ST_DONE;
        end
      end
      permt_pkg::ST_DIV: begin
        if (bit_cnt == '0) begin
          state_next = permt_pkg::ST_RD_I;
        end
      end
      permt_pkg::ST_RD_I: begin
        mem_ra     = shuffle_position[IDX_W-1:0];
        state_next = permt_pkg::ST_RD_J;
      end
      permt_pkg::ST_RD_J: begin
        mem_ra     = swap_j;
        state_next = permt_pkg::ST_WR_I;
      end
      permt_pkg::ST_WR_I: begin
        mem_we     = 1'b1;
        mem_wa     = shuffle_position[IDX_W-1:0];
        mem_wd     = rd_data;
        state_next = permt_pkg::ST_WR_J;
      end
      permt_pkg::ST_WR_J: begin
        mem_we                = 1'b1;
        mem_wa                = swap_j;
        mem_wd                = tmp;
        shuffle_position_next = shuffle_position + LEN_W'(1);
        state_next            = permt_pkg::ST_DONE;
      end
      permt_pkg::ST_LOOK: begin
        state_next = permt_pkg::ST_DONE;
      end
      permt_pkg::ST_SHORT: begin
        // Reads run one entry ahead of the compacting writes
        mem_ra = walk[IDX_W-1:0];
        if (pend && keep_entry) begin
          mem_we = 1'b1;
          mem_wa = wr_cnt[IDX_W-1:0];
          mem_wd = rd_data;
        end
        if (!walk_issue && !pend) begin
          table_length_next = wr_cnt;
          state_next        = permt_pkg::ST_DONE;
        end
      end
      permt_pkg::ST_DONE: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          state_next     = permt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = permt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      permt_pkg::ST_IDLE: begin
        num_reg  <= number;
        rnd_reg  <= random_word;
        div_reg  <= table_length - shuffle_position;
        rem      <= '0;
        bit_cnt  <= permt_pkg::CNT_W'(permt_pkg::RND_W - 1);
        walk     <= '0;
        wr_cnt   <= '0;
        pend     <= 1'b0;
        res_read <= (op == permt_pkg::OP_LOOKUP && number >= 8'(table_length)) ? number : 8'd0;
        res_err  <= (op == permt_pkg::OP_SHUFFLE && pos_at_end) ||
                    (op == permt_pkg::OP_APPEND && tbl_full);
      end
      permt_pkg::ST_FILL: begin
        walk <= walk + LEN_W'(1);
      end
      permt_pkg::ST_DIV: begin
        rem     <= div_ge ? div_sub[LEN_W-1:0] : div_shift[LEN_W-1:0];
        rnd_reg <= rnd_reg << 1;
        bit_cnt <= bit_cnt - permt_pkg::CNT_W'(1);
      end
      permt_pkg::ST_RD_I: begin
        swap_j <= j_sum[IDX_W-1:0];
      end
      permt_pkg::ST_RD_J: begin
        tmp <= rd_data;
      end
      permt_pkg::ST_LOOK: begin
        res_read <= 8'(rd_data);
      end
      permt_pkg::ST_SHORT: begin
        pend <= walk_issue;
        if (walk_issue) begin
          walk <= walk + LEN_W'(1);
        end
        if (pend && keep_entry) begin
          wr_cnt <= wr_cnt + LEN_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Result register: load on completion, hold while stalled
  always_ff @(posedge clk) begin
    if (state == permt_pkg::ST_DONE && slot_free) begin
      read_value   <= res_read;
      length       <= 8'(table_length);
      shuffle_done <= pos_at_end;
      error        <= res_err;
    end
  end

endmodule

>>> rtl/permt_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module permt_checker #(
  parameter int MAX_ENTRIES = 128
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [permt_pkg::OP_W-1:0]  op,
  input logic [permt_pkg::NUM_W-1:0] number,
  input logic [permt_pkg::VAL_W-1:0] entry_value,
  input logic [permt_pkg::RND_W-1:0] random_word,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [7:0]                  read_value,
  input logic [7:0]                  length,
  input logic                        shuffle_done,
  input logic                        error
);

  logic                       push;
  logic                       pop;
  logic [1:0]                 cnt;
  logic [permt_pkg::OP_W-1:0] q0;
  logic [permt_pkg::OP_W-1:0] q1;

  assign push = in_valid && !in_stall;
  assign pop  = out_valid && !out_stall;

  // Track the op of each request in flight; the head owns the current result
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      if (push && !pop) begin
        if (cnt == 2'd0) begin
          q0 <= op;
        end else begin
          q1 <= op;
        end
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        q0  <= q1;
        cnt <= cnt - 2'd1;
      end else if (push && pop) begin
        if (cnt == 2'd1) begin
          q0 <= op;
        end else begin
          q0 <= q1;
          q1 <= op;
        end
      end
    end
  end

  `PTE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped while stalled")
  `PTE_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(read_value) && $stable(length) && $stable(shuffle_done) && $stable(error), "stalled result changed")
  `PTE_ASSERT_NOW(a_len_cap, clk, rst, out_valid, length <= 8'(MAX_ENTRIES), "length beyond table depth")
  `PTE_ASSERT_NOW(a_err_op, clk, rst, out_valid && error, q0 == permt_pkg::OP_SHUFFLE || q0 == permt_pkg::OP_APPEND, "error on a request that cannot fail")
  `PTE_ASSERT_NOW(a_read_op, clk, rst, out_valid && read_value != 8'd0, q0 == permt_pkg::OP_LOOKUP, "read value on a non-lookup request")

  logic unused_ok;
  assign unused_ok = ^{number, entry_value, random_word, shuffle_done};

endmodule

bind permutation_table_engine permt_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_permt_checker (.*);
